// ===== design/rtti_pkg.sv =====
`timescale 1ns / 1ps

package rtti_pkg;

    localparam int RESULT_BITS_DEF = 32;
    localparam int CHAR_W          = 8;
    localparam int RADIX_W         = 6;
    localparam int STATUS_W        = 3;
    localparam int CFG_ADDR_W      = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_FIXED_RADIX = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_AUTO_BASE   = 1'd1;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SIGN     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADDIGIT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;
    localparam logic [STATUS_W-1:0] ST_PREFIX   = 3'd5;

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;

    localparam logic [RADIX_W-1:0] BASE_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] BASE_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] BASE_DEC = 6'd10;
    localparam logic [RADIX_W-1:0] BASE_OCT = 6'd8;
    localparam logic [RADIX_W-1:0] BASE_HEX = 6'd16;
    localparam logic [RADIX_W-1:0] DIGIT_BAD = 6'd63;

    typedef struct packed {
        logic bad_digit;
        logic overflow;
    } rtti_step_t;

    function automatic logic [RADIX_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        d = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            d = c - CH_LO_A + 8'd10;
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            d = c - CH_UP_A + 8'd10;
        end else begin
            d = {2'b00, DIGIT_BAD};
        end
        return d[RADIX_W-1:0];
    endfunction

endpackage

// ===== design/rtti_digit_step.sv =====
`timescale 1ns / 1ps

module rtti_digit_step #(
    parameter int RESULT_BITS = rtti_pkg::RESULT_BITS_DEF
) (
    input  logic [RESULT_BITS-1:0]      acc,
    input  logic [rtti_pkg::RADIX_W-1:0] base,
    input  logic [rtti_pkg::CHAR_W-1:0]  character,
    output logic [RESULT_BITS-1:0]      acc_next,
    output rtti_pkg::rtti_step_t        flags
);
    import rtti_pkg::*;

    localparam int PROD_W = RESULT_BITS + RADIX_W;
    localparam logic [PROD_W-1:0] LIMIT = PROD_W'(1) << (RESULT_BITS - 1);

    logic [RADIX_W-1:0] digit;
    logic [PROD_W-1:0]  product;
    logic [PROD_W-1:0]  sum;

    always_comb begin
        digit    = digit_value(character);
        product  = PROD_W'(acc) * PROD_W'(base);
        sum      = product + PROD_W'(digit);
        acc_next = sum[RESULT_BITS-1:0];
        flags.bad_digit = (digit >= base);
        flags.overflow  = !flags.bad_digit && (sum > LIMIT);
    end

endmodule

// ===== design/radix_text_to_integer.sv =====
`timescale 1ns / 1ps

// Streaming text-to-integer parser. Each input beat carries one ASCII character
// (tuser high) and tlast closes the string; the closing beat produces one
// result beat with the signed value and a status (0 ok, 1 empty, 2 sign only,
// 3 bad digit, 4 overflow, 5 prefix without digits; the value is zero unless
// the status is ok). One beat is accepted every cycle: each character passes
// through a single multiply-add digit step into the state registers, and the
// result sits in an output register. Input stalls only while that register
// holds a result that m_tready has not yet taken.
// The result is registered and shown in the cycle after its closing beat. fixed_radix and
// auto_base are sampled on the first character of a string.
module radix_text_to_integer #(
    parameter int RESULT_BITS = rtti_pkg::RESULT_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [rtti_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [rtti_pkg::RADIX_W-1:0]    cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] character
    input  logic                            s_tuser,   // has_char
    input  logic                            s_tlast,   // last
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // number, then status
    output logic [((RESULT_BITS+rtti_pkg::STATUS_W+7)/8)*8-1:0] m_tdata
);
    import rtti_pkg::*;

    localparam int DATA_W = ((RESULT_BITS + STATUS_W + 7) / 8) * 8;

    localparam logic [2:0] PH_START      = 3'd0;
    localparam logic [2:0] PH_SIGN_FIXED = 3'd1;
    localparam logic [2:0] PH_SIGN_AUTO  = 3'd2;
    localparam logic [2:0] PH_ZERO       = 3'd3;
    localparam logic [2:0] PH_PREFIX     = 3'd4;
    localparam logic [2:0] PH_DIGITS     = 3'd5;
    localparam logic [2:0] PH_ERROR      = 3'd6;

    logic [RADIX_W-1:0]     fixed_radix_reg;
    logic                   auto_base_reg;

    logic [2:0]             phase_reg, phase_next;
    logic                   neg_reg, neg_next;
    logic [RESULT_BITS-1:0] acc_reg, acc_next;
    logic [RADIX_W-1:0]     base_reg, base_next;
    logic [STATUS_W-1:0]    err_reg, err_next;

    logic                   out_valid_reg, out_valid_next;
    logic [RESULT_BITS-1:0] out_num_reg, out_num_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;

    logic [RADIX_W-1:0]     clamped_radix;
    logic [RADIX_W-1:0]     base_eff;
    logic [RESULT_BITS-1:0] step_acc;
    rtti_step_t             step_flags;
    logic                   take;
    logic                   use_digit;
    logic [CHAR_W-1:0]      ch;
    logic [STATUS_W-1:0]    status;

    assign ch       = s_tdata[CHAR_W-1:0];
    assign s_tready = !out_valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DATA_W'({out_status_reg, out_num_reg});

    always_comb begin
        clamped_radix = fixed_radix_reg;
        if (fixed_radix_reg < BASE_MIN) begin
            clamped_radix = BASE_MIN;
        end else if (fixed_radix_reg > BASE_MAX) begin
            clamped_radix = BASE_MAX;
        end
    end

    // pick the base the digit step sees this cycle, and whether this character is a digit
    always_comb begin
        base_eff  = base_reg;
        use_digit = 1'b0;
        unique case (phase_reg)
            PH_START: begin
                if (auto_base_reg) begin
                    base_eff  = BASE_DEC;
                    use_digit = (ch != CH_MINUS) && (ch != CH_ZERO) && (ch != CH_HASH);
                end else begin
                    base_eff  = clamped_radix;
                    use_digit = (ch != CH_MINUS);
                end
            end
            PH_SIGN_AUTO: begin
                base_eff  = BASE_DEC;
                use_digit = (ch != CH_ZERO) && (ch != CH_HASH);
            end
            PH_ZERO: begin
                base_eff  = BASE_OCT;
                use_digit = (ch != CH_LO_X) && (ch != CH_UP_X);
            end
            PH_SIGN_FIXED, PH_PREFIX, PH_DIGITS: begin
                use_digit = 1'b1;
            end
            default: begin
                use_digit = 1'b0;
            end
        endcase
    end

    rtti_digit_step #(
        .RESULT_BITS(RESULT_BITS)
    ) u_step (
        .acc      (acc_reg),
        .base     (base_eff),
        .character(ch),
        .acc_next (step_acc),
        .flags    (step_flags)
    );

    always_comb begin
        phase_next      = phase_reg;
        neg_next        = neg_reg;
        acc_next        = acc_reg;
        base_next       = base_reg;
        err_next        = err_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_num_next    = out_num_reg;
        out_status_next = out_status_reg;
        status          = ST_OK;

        if (take && s_tuser) begin
            if (use_digit) begin
                base_next = base_eff;
                if (step_flags.bad_digit) begin
                    err_next   = ST_BADDIGIT;
                    phase_next = PH_ERROR;
                end else if (step_flags.overflow) begin
                    err_next   = ST_OVERFLOW;
                    phase_next = PH_ERROR;
                end else begin
                    acc_next   = step_acc;
                    phase_next = PH_DIGITS;
                end
            end else begin
                unique case (phase_reg)
                    PH_START: begin
                        if (!auto_base_reg) begin
                            base_next = clamped_radix;
                        end
                        if (ch == CH_MINUS) begin
                            neg_next   = 1'b1;
                            phase_next = auto_base_reg ? PH_SIGN_AUTO : PH_SIGN_FIXED;
                        end else if (ch == CH_ZERO) begin
                            phase_next = PH_ZERO;
                        end else begin
                            base_next  = BASE_HEX;
                            phase_next = PH_PREFIX;
                        end
                    end
                    PH_SIGN_AUTO: begin
                        if (ch == CH_ZERO) begin
                            phase_next = PH_ZERO;
                        end else begin
                            base_next  = BASE_HEX;
                            phase_next = PH_PREFIX;
                        end
                    end
                    PH_ZERO: begin
                        base_next  = BASE_HEX;
                        phase_next = PH_PREFIX;
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end

        if (take && s_tlast) begin
            unique case (phase_next)
                PH_START:                    status = ST_EMPTY;
                PH_SIGN_FIXED, PH_SIGN_AUTO: status = ST_SIGN;
                PH_ZERO:                     status = ST_OK;
                PH_PREFIX:                   status = ST_PREFIX;
                PH_DIGITS:                   status = (!neg_next && acc_next[RESULT_BITS-1])
                                                      ? ST_OVERFLOW : ST_OK;
                default:                     status = err_next;
            endcase
            out_valid_next  = 1'b1;
            out_status_next = status;
            out_num_next    = '0;
            if (status == ST_OK && phase_next == PH_DIGITS) begin
                out_num_next = neg_next ? (~acc_next + 1'b1) : acc_next;
            end
            phase_next = PH_START;
            neg_next   = 1'b0;
            acc_next   = '0;
            base_next  = BASE_DEC;
            err_next   = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fixed_radix_reg <= BASE_DEC;
            auto_base_reg   <= 1'b0;
            phase_reg       <= PH_START;
            neg_reg         <= 1'b0;
            acc_reg         <= '0;
            base_reg        <= BASE_DEC;
            err_reg         <= ST_OK;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_FIXED_RADIX: fixed_radix_reg <= cfg_wdata;
                    REG_AUTO_BASE:   auto_base_reg   <= cfg_wdata[0];
                    default:         fixed_radix_reg <= fixed_radix_reg;
                endcase
            end
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            acc_reg       <= acc_next;
            base_reg      <= base_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_num_reg    <= out_num_next;
        out_status_reg <= out_status_next;
    end

endmodule
